@@ hw/rtl/cbs_pkg.sv @@
// Shared constants and types for the CR LF escape byte stuffer.
// Used by cbs_encode, cbs_emit and the top level; depends on nothing.
`default_nettype none

package cbs_pkg;

	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_ESC      = 8'hDB;
	localparam logic [7:0] CH_ESC_CRLF = 8'hDC;
	localparam logic [7:0] CH_ESC_ESC  = 8'hDD;

	localparam int BUDGET_BITS_DEF = 12;
	localparam int BUDGET_RESET    = 1024;
	localparam int COUNT_W         = 16;
	localparam int LEN_W           = 12;
	localparam int MAX_RES         = 3;

	// Up to three output words produced by one source word.
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] data;
		logic [1:0]              count;
		logic                    byte_valid;
		logic                    done;
		logic [COUNT_W-1:0]      consumed;
		logic [LEN_W-1:0]        stuffed;
	} cbs_bundle_t;

endpackage

`default_nettype wire

@@ hw/rtl/crlf_escape_byte_stuffer.sv @@
// Top level of the CR LF escape byte stuffer: input register, budget register,
// cbs_encode and cbs_emit. Depends on cbs_pkg.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------------
//  source    | src_valid / src_stall | data_byte, last_byte
//  result    | res_valid / res_stall | out_byte, byte_valid, run_end, message_done,
//            |                       | consumed_count, stuffed_length
//  config    | cfg_we                | output_budget
//
// A source word is held in the input register, then its zero to three output
// words leave the serializer at one per cycle unless res_stall holds them, so
// the serializer sets the rate, with a new source word taken as the last word
// of the previous one moves to the output register. Reset clears all control
// state and loads the budget of 1024 slots. A stall on the result side backs up
// into src_stall only once the serializer cannot drain.
`default_nettype none

module crlf_escape_byte_stuffer import cbs_pkg::*; #(
	parameter int BUDGET_BITS = BUDGET_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [BUDGET_BITS-1:0] output_budget,
	input  wire logic                   src_valid,
	output logic                        src_stall,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   last_byte,
	output logic                        res_valid,
	input  wire logic                   res_stall,
	output logic [7:0]                  out_byte,
	output logic                        byte_valid,
	output logic                        run_end,
	output logic                        message_done,
	output logic [COUNT_W-1:0]          consumed_count,
	output logic [LEN_W-1:0]            stuffed_length
);

	logic [BUDGET_BITS-1:0] budget_q;
	logic                   valid_s1;
	logic [7:0]             data_s1;
	logic                   last_s1;
	logic                   free;
	logic                   take;
	cbs_bundle_t            bundle;

	assign take = valid_s1 && free;
	assign src_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_BITS'(BUDGET_RESET);
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				budget_q <= output_budget;
			end
			if (!src_stall) begin
				valid_s1 <= src_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	cbs_encode #(
		.BUDGET_BITS(BUDGET_BITS)
	) u_encode (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (take),
		.data_s1 (data_s1),
		.last_s1 (last_s1),
		.budget  (budget_q),
		.bundle  (bundle)
	);

	cbs_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (take),
		.bundle         (bundle),
		.free           (free),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.run_end        (run_end),
		.message_done   (message_done),
		.consumed_count (consumed_count),
		.stuffed_length (stuffed_length)
	);

endmodule

`default_nettype wire

@@ hw/rtl/cbs_encode.sv @@
// Stuffing logic and per-message state for the CR LF escape byte stuffer.
// Depends on cbs_pkg for the escape codes and the bundle type.
`default_nettype none

module cbs_encode import cbs_pkg::*; #(
	parameter int BUDGET_BITS = BUDGET_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [7:0]             data_s1,
	input  wire logic                   last_s1,
	input  wire logic [BUDGET_BITS-1:0] budget,
	output cbs_bundle_t                 bundle
);

	localparam int WIDE = (BUDGET_BITS > LEN_W) ? BUDGET_BITS : LEN_W;

	logic                   pend_q;
	logic [BUDGET_BITS-1:0] slots_q;
	logic [COUNT_W-1:0]     taken_q;
	logic [BUDGET_BITS-1:0] written_q;

	logic                   pend_d;
	logic [BUDGET_BITS-1:0] slots_d;
	logic [COUNT_W-1:0]     taken_d;
	logic [BUDGET_BITS-1:0] written_d;
	logic [WIDE-1:0]        written_ext;

	always_comb begin
		logic                   pre;
		logic [1:0]             tn;
		logic [7:0]             t0;
		logic [7:0]             t1;
		logic [1:0]             n;
		logic [MAX_RES-1:0][7:0] dv;

		pre = 1'b0;
		tn = 2'd0;
		t0 = data_s1;
		t1 = CH_ESC_ESC;
		n = 2'd0;
		dv = '0;
		pend_d = 1'b0;
		slots_d = slots_q;
		taken_d = taken_q;
		written_d = written_q;

		if (pend_q && data_s1 == CH_LF) begin
			// The held CR and this LF leave as one escape pair.
			taken_d = taken_q + COUNT_W'(1);
			slots_d = (slots_q >= BUDGET_BITS'(2)) ? slots_q - BUDGET_BITS'(2) : '0;
			written_d = written_q + BUDGET_BITS'(2);
			dv[0] = CH_ESC;
			dv[1] = CH_ESC_CRLF;
			n = 2'd2;
		end else begin
			if (pend_q) begin
				pre = 1'b1;
				slots_d = (slots_q != '0) ? slots_q - BUDGET_BITS'(1) : '0;
				written_d = written_q + BUDGET_BITS'(1);
			end
			if (slots_d >= BUDGET_BITS'(2)) begin
				taken_d = taken_q + COUNT_W'(1);
				if (data_s1 == CH_CR && !last_s1) begin
					pend_d = 1'b1;
				end else if (data_s1 == CH_ESC) begin
					tn = 2'd2;
					t0 = CH_ESC;
					t1 = CH_ESC_ESC;
					slots_d = slots_d - BUDGET_BITS'(2);
					written_d = written_d + BUDGET_BITS'(2);
				end else begin
					tn = 2'd1;
					slots_d = slots_d - BUDGET_BITS'(1);
					written_d = written_d + BUDGET_BITS'(1);
				end
			end
			if (pre) begin
				dv[0] = CH_CR;
				dv[1] = t0;
				dv[2] = t1;
				n = tn + 2'd1;
			end else begin
				dv[0] = t0;
				dv[1] = t1;
				n = tn;
			end
		end

		written_ext = WIDE'(written_d);
		bundle.data = dv;
		bundle.count = n;
		bundle.byte_valid = 1'b1;
		bundle.done = last_s1;
		bundle.consumed = taken_d;
		bundle.stuffed = written_ext[LEN_W-1:0];
		// A final word that produces nothing still reports the totals.
		if (last_s1 && n == 2'd0) begin
			bundle.data = '0;
			bundle.count = 2'd1;
			bundle.byte_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			slots_q <= BUDGET_BITS'(BUDGET_RESET);
			taken_q <= '0;
			written_q <= '0;
		end else if (step) begin
			if (last_s1) begin
				pend_q <= 1'b0;
				slots_q <= budget;
				taken_q <= '0;
				written_q <= '0;
			end else begin
				pend_q <= pend_d;
				slots_q <= slots_d;
				taken_q <= taken_d;
				written_q <= written_d;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/cbs_emit.sv @@
// Result register and serializer: holds one bundle and sends its words out in order.
// Depends on cbs_pkg for the bundle type and field widths.
`default_nettype none

module cbs_emit import cbs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire cbs_bundle_t        bundle,
	output logic                    free,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [7:0]              out_byte,
	output logic                    byte_valid,
	output logic                    run_end,
	output logic                    message_done,
	output logic [COUNT_W-1:0]      consumed_count,
	output logic [LEN_W-1:0]        stuffed_length
);

	cbs_bundle_t bun_q;
	logic [1:0]  idx_q;
	logic        busy_q;
	logic        valid_q;
	logic        load_out;
	logic        last_entry;
	logic        fin;

	assign last_entry = (idx_q == bun_q.count - 2'd1);
	assign load_out = busy_q && (!valid_q || !res_stall);
	assign free = !busy_q || (load_out && last_entry);
	assign fin = last_entry && bun_q.done;
	assign res_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			// A source word that produced nothing leaves the serializer untouched.
			if (load && bundle.count != 2'd0) begin
				busy_q <= 1'b1;
				idx_q <= 2'd0;
			end else if (load_out) begin
				if (last_entry) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (load_out) begin
				valid_q <= 1'b1;
			end else if (!res_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && bundle.count != 2'd0) begin
			bun_q <= bundle;
		end
		if (load_out) begin
			out_byte <= bun_q.data[idx_q];
			byte_valid <= bun_q.byte_valid;
			run_end <= last_entry;
			message_done <= fin;
			consumed_count <= fin ? bun_q.consumed : '0;
			stuffed_length <= fin ? bun_q.stuffed : '0;
		end
	end

endmodule

`default_nettype wire

@@ tb/crlf_escape_byte_stuffer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for crlf_escape_byte_stuffer: directed and random messages are
// stuffed by an in-bench predictor and every output word is compared with it.
// Depends on cbs_pkg and the RTL of the block only.

module crlf_escape_byte_stuffer_tb;
	import cbs_pkg::*;

	localparam int BB           = BUDGET_BITS_DEF;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_WORDS  = 45;

	typedef struct packed {
		logic [7:0]         data;
		logic               byte_valid;
		logic               run_end;
		logic               done;
		logic [COUNT_W-1:0] consumed;
		logic [LEN_W-1:0]   stuffed;
	} out_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [BB-1:0]      output_budget = '0;
	logic               src_valid = 1'b0;
	logic               src_stall;
	logic [7:0]         data_byte = '0;
	logic               last_byte = 1'b0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic [7:0]         out_byte;
	logic               byte_valid;
	logic               run_end;
	logic               message_done;
	logic [COUNT_W-1:0] consumed_count;
	logic [LEN_W-1:0]   stuffed_length;

	// Predictor state: one message in progress.
	logic [BB-1:0]      budget_reg;
	bit                 held_cr;
	logic [BB-1:0]      room_left;
	logic [COUNT_W-1:0] src_taken;
	logic [BB-1:0]      out_written;
	out_word_t          item_words[$];
	out_word_t          expected_words[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int messages_sent = 0;
	int budget_writes = 0;
	int backpressure_cycles = 0;

	crlf_escape_byte_stuffer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.output_budget(output_budget),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.run_end(run_end),
		.message_done(message_done),
		.consumed_count(consumed_count),
		.stuffed_length(stuffed_length)
	);

	always #5 clk = ~clk;

	task automatic begin_new_message();
		held_cr = 1'b0;
		room_left = budget_reg;
		src_taken = '0;
		out_written = '0;
	endtask

	task automatic emit_stuffed(input logic [7:0] b);
		out_word_t w;
		w = '0;
		w.data = b;
		w.byte_valid = 1'b1;
		item_words.push_back(w);
		out_written = out_written + 1'b1;
	endtask

	// A fresh source byte needs two free slots, whatever it turns into.
	task automatic take_source(input logic [7:0] b, input bit l);
		if (room_left >= 2) begin
			src_taken = src_taken + 1'b1;
			if (b == CH_CR && !l) begin
				held_cr = 1'b1;
			end else if (b == CH_ESC) begin
				emit_stuffed(CH_ESC);
				emit_stuffed(CH_ESC_ESC);
				room_left = room_left - 2'd2;
			end else begin
				emit_stuffed(b);
				room_left = room_left - 1'b1;
			end
		end
	endtask

	task automatic predict_stuffing(input logic [7:0] d, input bit l);
		out_word_t w;
		item_words.delete();
		if (held_cr) begin
			held_cr = 1'b0;
			if (d == CH_LF) begin
				src_taken = src_taken + 1'b1;
				emit_stuffed(CH_ESC);
				emit_stuffed(CH_ESC_CRLF);
				room_left = (room_left >= 2) ? room_left - 2'd2 : '0;
			end else begin
				emit_stuffed(CH_CR);
				room_left = (room_left >= 1) ? room_left - 1'b1 : '0;
				take_source(d, l);
			end
		end else begin
			take_source(d, l);
		end
		if (l) begin
			if (item_words.size() == 0)
				item_words.push_back('0);
			w = item_words[item_words.size() - 1];
			w.run_end = 1'b1;
			w.done = 1'b1;
			w.consumed = src_taken;
			w.stuffed = LEN_W'(out_written);
			item_words[item_words.size() - 1] = w;
			begin_new_message();
		end else if (item_words.size() > 0) begin
			w = item_words[item_words.size() - 1];
			w.run_end = 1'b1;
			item_words[item_words.size() - 1] = w;
		end
		foreach (item_words[i])
			expected_words.push_back(item_words[i]);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on output word %0d: %s is %0h, expected %0h",
			words_checked, what, got, want);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	always @(posedge clk) begin : check_words
		out_word_t w;
		if (arst_n && res_valid === 1'b1 && res_stall == 1'b0) begin
			if (expected_words.size() == 0) begin
				report_mismatch("word with nothing expected, out_byte", out_byte, 0);
			end else begin
				w = expected_words.pop_front();
				check_field("out_byte", out_byte, w.data);
				check_field("byte_valid", byte_valid, w.byte_valid);
				check_field("run_end", run_end, w.run_end);
				check_field("message_done", message_done, w.done);
				check_field("consumed_count", consumed_count, w.consumed);
				check_field("stuffed_length", stuffed_length, w.stuffed);
			end
			words_checked++;
		end
		if (src_valid && src_stall === 1'b1)
			backpressure_cycles++;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Output side: random stall, or a long hold when a test asks for one.
	always @(negedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			res_stall = 1'b1;
			hold_left--;
		end else begin
			res_stall = ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_word(input logic [7:0] d, input bit l);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			src_valid = 1'b0;
			@(negedge clk);
		end
		src_valid = 1'b1;
		data_byte = d;
		last_byte = l;
		do @(posedge clk); while (src_stall);
		predict_stuffing(d, l);
		words_sent++;
		if (l)
			messages_sent++;
	endtask

	task automatic send_message(input logic [7:0] msg[$]);
		foreach (msg[i])
			send_word(msg[i], i == msg.size() - 1);
	endtask

	// Held CRs and dropped bytes give no output, so an extra wait follows the drain.
	task automatic wait_idle();
		@(negedge clk);
		src_valid = 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_budget(input logic [BB-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we = 1'b1;
		output_budget = v;
		@(posedge clk);
		budget_reg = v;
		budget_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [7:0] pick_source_byte();
		case ($urandom_range(9))
			0, 1: return CH_CR;
			2: return CH_LF;
			3: return CH_ESC;
			4: return $urandom_range(1) ? CH_ESC_CRLF : CH_ESC_ESC;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly small budgets so that messages run out of room.
	function automatic logic [BB-1:0] pick_budget();
		case ($urandom_range(19))
			0, 1, 2, 3, 4: return BB'($urandom_range(3));
			5, 6, 7, 8, 9, 10, 11, 12, 13, 14: return BB'($urandom_range(4, 16));
			15, 16, 17, 18: return BB'($urandom_range((1 << BB) - 1));
			default: return '1;
		endcase
	endfunction

	// Budget takes effect one message end after the write, so each write in the budget
	// limits test is followed by a one-word message before the case that needs it.
	task automatic test_stuffing_rules();
		send_message('{8'h00, 8'hFF, CH_ESC, CH_CR, CH_LF, CH_CR, CH_ESC_CRLF,
			CH_CR, CH_ESC, CH_LF});
		send_message('{CH_CR});
		wait_idle();
	endtask

	task automatic test_budget_limits();
		write_budget('0);
		send_message('{8'h11});
		send_message('{8'h22, CH_ESC});
		write_budget(BB'(2));
		send_message('{8'h33});
		send_message('{CH_CR, CH_LF, 8'h44});
		write_budget(BB'(3));
		send_message('{8'h55});
		send_message('{CH_CR, 8'h42, CH_ESC});
		// Write while a message is open: it must not touch the current one.
		send_word(CH_ESC, 1'b0);
		write_budget('1);
		send_word(8'h66, 1'b1);
		send_message('{8'h01, CH_ESC});
		wait_idle();
	endtask

	task automatic test_full_output_hold();
		logic [7:0] msg[$];
		wait_idle();
		idle_pct = 0;
		stall_pct = 0;
		write_budget(BB'(BUDGET_RESET));
		@(posedge clk);
		hold_requests++;
		for (int i = 0; i < 16; i++)
			msg.push_back((i % 3 == 0) ? CH_CR : CH_ESC);
		send_message(msg);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int idle, input int stall, input int n_words);
		logic [7:0] msg[$];
		int stop_at;
		int len;
		wait_idle();
		idle_pct = idle;
		stall_pct = stall;
		write_budget(pick_budget());
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			if ($urandom_range(9) == 0)
				write_budget(pick_budget());
			len = ($urandom_range(19) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10);
			msg.delete();
			for (int i = 0; i < len; i++)
				msg.push_back(pick_source_byte());
			send_message(msg);
		end
		wait_idle();
	endtask

	initial begin
		budget_reg = BB'(BUDGET_RESET);
		begin_new_message();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_stuffing_rules();
		test_budget_limits();
		test_full_output_hold();
		test_random_traffic(0, 0, PHASE_WORDS);
		test_random_traffic(71, 0, PHASE_WORDS);
		test_random_traffic(0, 71, PHASE_WORDS);
		test_random_traffic(7, 7, PHASE_WORDS);
		wait_idle();

		$display("Stuffed %0d source words in %0d messages, %0d output words compared,",
			words_sent, messages_sent, words_checked);
		$display("%0d budget writes, input held off for %0d cycles, %0d mismatches.",
			budget_writes, backpressure_cycles, errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
